### hdl/trie_pkg.sv
`default_nettype none

package trie_pkg;

  // command codes, taken from the first item of a key
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_PREFIX = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // lowest key character, '0'
  localparam logic [7:0] FIRST_SYMBOL = 8'd48;

  // width of a value handle
  localparam int VALUE_W = 16;

  // controller states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_NODE  = 5'b01000,
    ST_END   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

### hdl/trie_insert_search_prefix_match.sv
`default_nettype none

// Character trie with insert, exact search and longest prefix match.
// Input channel: an item is taken on a rising edge with start high and busy
// low. Keys stream in one character per item; the first item of a key picks
// the command, key_last ends it, has_symbol low marks an item with no character.
// Result channel: one result per key, on the item with key_last set. done is
// high for exactly one cycle with found, value_out and error_code valid;
// the receiver cannot stall, so results are never held back.
// States: a character that is walked goes through ST_WALK, then through ST_NODE
// when a search or prefix match finds a child and either the command is prefix
// match or the item ends the key, as the child-table read data addresses the
// node-table read; busy is high in all but the cycle the item is taken in. Any
// other item goes through ST_NODE only on the first or last item of a key. Ending
// a key adds ST_END; done rises at the edge where busy falls.
// Reset: the child table and node table are swept to zero, one entry a cycle,
// over all NODE_COUNT*ALPHABET child slots (76800 at the defaults) with busy high;
// after that the trie is empty and the pool holds only the root.
module trie_insert_search_prefix_match
  import trie_pkg::*;
#(
  parameter int NODE_COUNT = 1024,
  parameter int ALPHABET   = 75
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         cmd,
  input  wire logic               has_symbol,
  input  wire logic [7:0]         symbol,
  input  wire logic               key_last,
  input  wire logic [VALUE_W-1:0] value_handle,
  output logic                    done,
  output logic                    found,
  output logic      [VALUE_W-1:0] value_out,
  output logic      [1:0]         error_code
);

  localparam int NB    = $clog2(NODE_COUNT);
  localparam int IB    = $clog2(ALPHABET);
  localparam int SLOTS = NODE_COUNT * ALPHABET;
  localparam int SB    = $clog2(SLOTS);
  localparam int NW    = VALUE_W + 1;

  state_t               state;
  logic                 key_active;
  logic [1:0]           active_cmd;
  logic [NB-1:0]        current_node;
  logic [NB:0]          next_free_node;
  logic                 best_valid;
  logic [VALUE_W-1:0]   best_value;
  logic                 walk_stopped;
  logic [1:0]           pending_error;
  logic                 it_last;
  logic [VALUE_W-1:0]   it_handle;
  logic [SB-1:0]        it_slot;
  logic                 root_pend;
  logic                 child_pend;
  logic                 node_flag;
  logic [VALUE_W-1:0]   node_val;
  logic [SB-1:0]        clr_addr;

  logic                 accept;
  logic                 new_key;
  logic [1:0]           cmd_eff;
  logic [1:0]           err_eff;
  logic                 stop_eff;
  logic [NB-1:0]        cur_eff;
  logic [8:0]           sym_off;
  logic                 in_range;
  logic                 try_char;
  logic                 walk;
  logic [SB-1:0]        slot;

  logic                 child_rd_en;
  logic [NB-1:0]        child_rd_data;
  logic                 child_wr_en;
  logic [SB-1:0]        child_wr_addr;
  logic [NB-1:0]        child_wr_data;
  logic                 child_zero;
  logic                 pool_full;

  logic                 node_rd_en;
  logic [NB-1:0]        node_rd_addr;
  logic [NW-1:0]        node_rd_data;
  logic                 node_wr_en;
  logic [NB-1:0]        node_wr_addr;
  logic [NW-1:0]        node_wr_data;
  logic                 q_flag;
  logic [VALUE_W-1:0]   q_val;

  // handshake
  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;

  // key context as seen by the incoming item
  assign new_key  = ~key_active;
  assign cmd_eff  = new_key ? ((cmd == CMD_UNUSED) ? CMD_SEARCH : cmd) : active_cmd;
  assign err_eff  = new_key ? ERR_NONE : pending_error;
  assign stop_eff = new_key ? 1'b0 : walk_stopped;
  assign cur_eff  = new_key ? '0 : current_node;

  // character range check and child slot address
  assign sym_off  = {1'b0, symbol} - {1'b0, FIRST_SYMBOL};
  assign in_range = (symbol >= FIRST_SYMBOL) && (sym_off < 9'(ALPHABET));
  assign try_char = has_symbol && (err_eff == ERR_NONE) && !stop_eff;
  assign walk     = try_char && in_range;
  assign slot     = SB'(cur_eff) * SB'(ALPHABET) + SB'(sym_off[IB-1:0]);

  assign child_zero = (child_rd_data == '0);
  assign pool_full  = (next_free_node >= (NB+1)'(NODE_COUNT));
  assign q_flag     = node_rd_data[NW-1];
  assign q_val      = node_rd_data[VALUE_W-1:0];

  // child table port control: sweep, allocation, walk read
  always_comb begin
    child_rd_en   = accept & walk;
    child_wr_en   = 1'b0;
    child_wr_addr = it_slot;
    child_wr_data = next_free_node[NB-1:0];
    if (state == ST_CLEAR) begin
      child_wr_en   = 1'b1;
      child_wr_addr = clr_addr;
      child_wr_data = '0;
    end else if (state == ST_WALK) begin
      child_wr_en = (active_cmd == CMD_INSERT) & child_zero & ~pool_full;
    end
  end

  // node table port control: sweep, word end write, flag and value reads
  always_comb begin
    node_rd_en   = accept;
    node_rd_addr = cur_eff;
    node_wr_en   = 1'b0;
    node_wr_addr = current_node;
    node_wr_data = {1'b1, it_handle};
    if (state == ST_WALK) begin
      node_rd_en   = (active_cmd != CMD_INSERT) & ~child_zero;
      node_rd_addr = child_rd_data;
    end
    if (state == ST_CLEAR) begin
      node_wr_en   = (clr_addr < SB'(NODE_COUNT));
      node_wr_addr = clr_addr[NB-1:0];
      node_wr_data = '0;
    end else if (state == ST_END) begin
      node_wr_en = (active_cmd == CMD_INSERT) & (pending_error == ERR_NONE);
    end
  end

  // child table: one node index per (node, character) slot
  trie_ram #(
    .DEPTH (SLOTS),
    .AW    (SB),
    .DW    (NB)
  ) u_child_ram (
    .clk     (clk),
    .rd_en   (child_rd_en),
    .rd_addr (slot),
    .rd_data (child_rd_data),
    .wr_en   (child_wr_en),
    .wr_addr (child_wr_addr),
    .wr_data (child_wr_data)
  );

  // node table: word end flag and value handle per node
  trie_ram #(
    .DEPTH (NODE_COUNT),
    .AW    (NB),
    .DW    (NW)
  ) u_node_ram (
    .clk     (clk),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_data),
    .wr_en   (node_wr_en),
    .wr_addr (node_wr_addr),
    .wr_data (node_wr_data)
  );

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      it_handle <= value_handle;
      it_slot   <= slot;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      key_active     <= 1'b0;
      active_cmd     <= CMD_INSERT;
      current_node   <= '0;
      next_free_node <= (NB+1)'(1);
      best_valid     <= 1'b0;
      best_value     <= '0;
      walk_stopped   <= 1'b0;
      pending_error  <= ERR_NONE;
      it_last        <= 1'b0;
      root_pend      <= 1'b0;
      child_pend     <= 1'b0;
      node_flag      <= 1'b0;
      node_val       <= '0;
      done           <= 1'b0;
      found          <= 1'b0;
      value_out      <= '0;
      error_code     <= ERR_NONE;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + SB'(1);
          if (clr_addr == SB'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            it_last    <= key_last;
            root_pend  <= new_key;
            child_pend <= 1'b0;
            // open a new key at the root
            if (new_key) begin
              key_active    <= 1'b1;
              active_cmd    <= cmd_eff;
              current_node  <= '0;
              walk_stopped  <= 1'b0;
              best_valid    <= 1'b0;
              best_value    <= '0;
              pending_error <= ERR_NONE;
            end
            if (try_char && !in_range) begin
              pending_error <= ERR_RANGE;
            end
            if (walk) begin
              state <= ST_WALK;
            end else if (new_key || key_last) begin
              state <= ST_NODE;
            end
          end
        end

        ST_WALK: begin
          // root word end seeds the best prefix
          if (root_pend) begin
            best_valid <= q_flag;
            best_value <= q_flag ? q_val : '0;
          end
          root_pend <= 1'b0;
          if (active_cmd == CMD_INSERT) begin
            if (child_zero) begin
              if (pool_full) begin
                pending_error <= ERR_FULL;
              end else begin
                current_node   <= next_free_node[NB-1:0];
                next_free_node <= next_free_node + (NB+1)'(1);
              end
            end else begin
              current_node <= child_rd_data;
            end
            state <= it_last ? ST_END : ST_IDLE;
          end else if (child_zero) begin
            walk_stopped <= 1'b1;
            state        <= it_last ? ST_END : ST_IDLE;
          end else begin
            current_node <= child_rd_data;
            child_pend   <= 1'b1;
            state        <= ((active_cmd == CMD_PREFIX) || it_last) ? ST_NODE : ST_IDLE;
          end
        end

        ST_NODE: begin
          // node flag and value back from the node table
          if (root_pend) begin
            best_valid <= q_flag;
            best_value <= q_flag ? q_val : '0;
          end else if (child_pend && (active_cmd == CMD_PREFIX) && q_flag) begin
            best_valid <= 1'b1;
            best_value <= q_val;
          end
          node_flag  <= q_flag;
          node_val   <= q_val;
          root_pend  <= 1'b0;
          child_pend <= 1'b0;
          state      <= it_last ? ST_END : ST_IDLE;
        end

        ST_END: begin
          // key result
          key_active <= 1'b0;
          done       <= 1'b1;
          error_code <= pending_error;
          found      <= 1'b0;
          value_out  <= '0;
          if (pending_error == ERR_NONE) begin
            if (active_cmd == CMD_INSERT) begin
              found     <= 1'b1;
              value_out <= it_handle;
            end else if (active_cmd == CMD_PREFIX) begin
              found     <= best_valid;
              value_out <= best_valid ? best_value : '0;
            end else if (!walk_stopped && node_flag) begin
              found     <= 1'b1;
              value_out <= node_val;
            end
          end
          state <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/trie_ram.sv
`default_nettype none

module trie_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 17
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // one read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### tb/sv/trie_insert_search_prefix_match_test.sv
`timescale 1ns / 1ps

module trie_insert_search_prefix_match_test;
  import trie_pkg::*;

  localparam int NODES = 1024;
  localparam int ALPHA = 75;
  localparam int MAX_KEY = 16;
  localparam int KNOWN = 64;
  localparam int WATCHDOG_LIMIT = 250000;
  localparam int SETTLE_CYCLES = 20;

  // one result of a finished key
  typedef struct {
    logic               found;
    logic [VALUE_W-1:0] value;
    logic [1:0]         err;
  } trie_answer_t;

  // shadow copy of the trie that works out the result of every finished key
  class trie_mirror;
    logic [9:0]         child_of [NODES*ALPHA];
    bit                 word_end [NODES];
    logic [VALUE_W-1:0] stored [NODES];
    int                 free_node;
    int                 at_node;
    bit                 in_key;
    bit                 stopped;
    bit                 best_ok;
    logic [1:0]         op;
    logic [1:0]         err;
    logic [VALUE_W-1:0] best_val;
    trie_answer_t       answers_due [$];
    int                 mismatches;

    function new();
      foreach (child_of[i]) child_of[i] = '0;
      foreach (word_end[i]) begin
        word_end[i] = 1'b0;
        stored[i] = '0;
      end
      free_node = 1;
      at_node = 0;
      in_key = 1'b0;
      stopped = 1'b0;
      best_ok = 1'b0;
      op = CMD_INSERT;
      err = ERR_NONE;
      best_val = '0;
      mismatches = 0;
    endfunction

    // note an accepted item and queue the result it causes, if any
    function void take_item(logic [1:0] cmd, logic has_sym, logic [7:0] sym, logic last,
                            logic [VALUE_W-1:0] handle);
      int slot;
      int child;
      int idx;
      trie_answer_t ans;
      // first item of a key picks the command and restarts the walk at the root
      if (!in_key) begin
        in_key = 1'b1;
        op = (cmd == CMD_UNUSED) ? CMD_SEARCH : cmd;
        at_node = 0;
        stopped = 1'b0;
        err = ERR_NONE;
        best_ok = word_end[0];
        best_val = best_ok ? stored[0] : '0;
      end
      // one character step of the walk
      idx = int'(sym) - int'(FIRST_SYMBOL);
      if (has_sym && err == ERR_NONE && !stopped) begin
        if (idx < 0 || idx >= ALPHA) begin
          err = ERR_RANGE;
        end else begin
          slot = at_node * ALPHA + idx;
          child = int'(child_of[slot]);
          if (op == CMD_INSERT) begin
            if (child == 0 && free_node >= NODES) begin
              err = ERR_FULL;
            end else begin
              if (child == 0) begin
                child = free_node;
                free_node++;
                word_end[child] = 1'b0;
                child_of[slot] = 10'(child);
              end
              at_node = child;
            end
          end else if (child == 0) begin
            stopped = 1'b1;
          end else begin
            at_node = child;
            if (op == CMD_PREFIX && word_end[child]) begin
              best_ok = 1'b1;
              best_val = stored[child];
            end
          end
        end
      end
      // key end gives the single result
      if (last) begin
        in_key = 1'b0;
        ans.found = 1'b0;
        ans.value = '0;
        ans.err = err;
        if (err == ERR_NONE) begin
          if (op == CMD_INSERT) begin
            word_end[at_node] = 1'b1;
            stored[at_node] = handle;
            ans.found = 1'b1;
            ans.value = handle;
          end else if (op == CMD_PREFIX) begin
            if (best_ok) begin
              ans.found = 1'b1;
              ans.value = best_val;
            end
          end else if (!stopped && word_end[at_node]) begin
            ans.found = 1'b1;
            ans.value = stored[at_node];
          end
        end
        answers_due.push_back(ans);
      end
    endfunction

    // compare one result with the oldest one due
    function void check_result(logic f, logic [VALUE_W-1:0] v, logic [1:0] e);
      trie_answer_t ans;
      if (answers_due.size() == 0) begin
        $error("result with no item waiting: found %0d value %0h error %0d", f, v, e);
        mismatches++;
      end else begin
        ans = answers_due.pop_front();
        if (f !== ans.found) begin
          $error("found: expected %0d, got %0d", ans.found, f);
          mismatches++;
        end
        if (v !== ans.value) begin
          $error("value_out: expected %0h, got %0h", ans.value, v);
          mismatches++;
        end
        if (e !== ans.err) begin
          $error("error_code: expected %0d, got %0d", ans.err, e);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         cmd;
  logic               has_symbol;
  logic [7:0]         symbol;
  logic               key_last;
  logic [VALUE_W-1:0] value_handle;
  logic               done;
  logic               found;
  logic [VALUE_W-1:0] value_out;
  logic [1:0]         error_code;

  trie_mirror mirror = new();

  int items_sent;
  int idle_cycles;
  bit steady;
  logic [7:0] key_buf [MAX_KEY];
  logic [7:0] known_key [KNOWN][MAX_KEY];
  int known_len [KNOWN];
  int known_cnt;
  int known_next;

  trie_insert_search_prefix_match #(
    .NODE_COUNT(NODES),
    .ALPHABET  (ALPHA)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .has_symbol  (has_symbol),
    .symbol      (symbol),
    .key_last    (key_last),
    .value_handle(value_handle),
    .done        (done),
    .found       (found),
    .value_out   (value_out),
    .error_code  (error_code)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      mirror.check_result(found, value_out, error_code);
    end
  end

  // watchdog on cycles where neither an item nor a result moves
  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drive one item, wait for it to be taken, then at times idle with start low
  task automatic send_item(input logic [1:0] c, input logic hs, input logic [7:0] sym,
                           input logic last, input logic [VALUE_W-1:0] handle);
    int gap;
    int r;
    @(negedge clk);
    cmd = c;
    has_symbol = hs;
    symbol = sym;
    key_last = last;
    value_handle = handle;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.take_item(c, hs, sym, last, handle);
    items_sent++;
    r = $urandom_range(0, 99);
    if (steady || r < 50) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 15);
    else gap = $urandom_range(20, 80);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      cmd = 2'($urandom);
      has_symbol = 1'($urandom);
      symbol = 8'($urandom);
      key_last = 1'($urandom);
      value_handle = 16'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stream key_buf[0..n-1] as one key, with the odd empty item mixed in
  task automatic stream_key(input logic [1:0] op, input int n);
    bit first;
    bit tail_sym;
    first = 1'b1;
    tail_sym = ($urandom_range(0, 9) != 0);
    steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(first ? op : 2'($urandom), 1'b0, 8'($urandom), 1'b0, 16'($urandom));
        first = 1'b0;
      end
      send_item(first ? op : 2'($urandom), 1'b1, key_buf[i], (i == n - 1) && tail_sym,
                16'($urandom));
      first = 1'b0;
    end
    if (n == 0 || !tail_sym) begin
      send_item(first ? op : 2'($urandom), 1'b0, 8'($urandom), 1'b1, 16'($urandom));
    end
  endtask

  // key character: full range, or a small set that makes paths collide
  function automatic logic [7:0] pick_symbol(input bit wide);
    if (wide) return 8'($urandom_range(48, 122));
    case ($urandom_range(0, 3))
      0: return "0";
      1: return "a";
      2: return "b";
      default: return "z";
    endcase
  endfunction

  // one random key: new or reused, at times with a bad character
  task automatic random_key(input bit wide, input int max_len, input int insert_pct);
    logic [1:0] op;
    int n;
    int pick;
    int r;
    bit bad;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      op = CMD_INSERT;
    end else begin
      r = $urandom_range(0, 9);
      op = (r < 4) ? CMD_SEARCH : (r < 8) ? CMD_PREFIX : CMD_UNUSED;
    end
    if (op != CMD_INSERT && known_cnt > 0 && $urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, known_cnt - 1);
      n = known_len[pick];
      for (int i = 0; i < n; i++) key_buf[i] = known_key[pick][i];
      r = $urandom_range(0, 3);
      if (r == 0 && n > 0) begin
        n--;
      end else if (r == 1 && n < MAX_KEY) begin
        key_buf[n] = pick_symbol(wide);
        n++;
      end
    end else begin
      n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, max_len);
      for (int i = 0; i < n; i++) key_buf[i] = pick_symbol(wide);
    end
    bad = 1'b0;
    if (n > 0 && $urandom_range(0, 24) == 0) begin
      bad = 1'b1;
      key_buf[$urandom_range(0, n - 1)] = $urandom_range(0, 1) ?
          8'($urandom_range(0, 47)) : 8'($urandom_range(123, 255));
    end
    stream_key(op, n);
    // remember clean inserts so later searches hit
    if (op == CMD_INSERT && !bad) begin
      for (int i = 0; i < n; i++) known_key[known_next][i] = key_buf[i];
      known_len[known_next] = n;
      known_next = (known_next + 1) % KNOWN;
      if (known_cnt < KNOWN) known_cnt++;
    end
  endtask

  initial begin
    int target;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_INSERT;
    has_symbol = 1'b0;
    symbol = '0;
    key_last = 1'b0;
    value_handle = '0;
    items_sent = 0;
    idle_cycles = 0;
    steady = 1'b0;
    known_cnt = 0;
    known_next = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty keys on an empty trie
    send_item(CMD_PREFIX, 1'b0, 8'h00, 1'b1, 16'h0000);
    send_item(CMD_SEARCH, 1'b0, 8'hff, 1'b1, 16'hffff);
    // lowest and highest characters, extreme handles
    send_item(CMD_INSERT, 1'b1, "0", 1'b1, 16'h0000);
    send_item(CMD_INSERT, 1'b1, "z", 1'b1, 16'hffff);
    // empty key insert marks the root
    send_item(CMD_INSERT, 1'b0, 8'h00, 1'b1, 16'ha5a5);
    send_item(CMD_PREFIX, 1'b0, 8'h00, 1'b1, 16'h0000);
    // prefix match stops at a missing child, keeps the deepest word
    send_item(CMD_PREFIX, 1'b1, "0", 1'b0, 16'h0000);
    send_item(CMD_PREFIX, 1'b1, "z", 1'b1, 16'h0000);
    // unused command acts as exact search
    send_item(CMD_UNUSED, 1'b1, "z", 1'b1, 16'h0000);
    // character below and above the range
    send_item(CMD_INSERT, 1'b1, 8'd47, 1'b0, 16'h1111);
    send_item(CMD_INSERT, 1'b1, "a", 1'b1, 16'h2222);
    send_item(CMD_SEARCH, 1'b1, 8'd123, 1'b1, 16'h0000);
    // after a stopped walk a bad character is not checked
    send_item(CMD_SEARCH, 1'b1, "q", 1'b0, 16'h0000);
    send_item(CMD_SEARCH, 1'b1, 8'hff, 1'b1, 16'h0000);
    // empty item inside a key
    send_item(CMD_INSERT, 1'b1, "a", 1'b0, 16'h0000);
    send_item(CMD_SEARCH, 1'b0, 8'h00, 1'b0, 16'h0000);
    send_item(CMD_PREFIX, 1'b1, "b", 1'b1, 16'h5a5a);
    send_item(CMD_PREFIX, 1'b1, "a", 1'b0, 16'h0000);
    send_item(CMD_INSERT, 1'b1, "b", 1'b0, 16'h0000);
    send_item(CMD_SEARCH, 1'b1, "c", 1'b1, 16'h0000);
    // interior node that is not a word
    send_item(CMD_SEARCH, 1'b1, "a", 1'b1, 16'h0000);
    send_item(CMD_PREFIX, 1'b1, 8'h00, 1'b1, 16'h0000);
    send_item(CMD_INSERT, 1'b1, "a", 1'b1, 16'h1234);

    // random keys over a few characters so searches hit often
    target = items_sent + 100;
    while (items_sent < target) random_key($urandom_range(0, 3) == 0, 5, 35);
    // long inserts until the node pool runs out
    while (mirror.free_node < NODES) random_key(1'b1, 12, 100);
    // mixed traffic on a full pool
    target = (items_sent + 100 > 1400) ? items_sent + 100 : 1400;
    while (items_sent < target) random_key($urandom_range(0, 1) == 1, 6, 40);

    @(negedge clk);
    start = 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.answers_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
